// ----- hdl/asrt_pkg.sv -----
// ----------------------------------------------------------------------------
// asrt_pkg: shared types and constants for the box scale/rotate/translate unit
// Coordinate and matrix types, register indexes and reset values, saturation.
// ----------------------------------------------------------------------------
package asrt_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic [47:0]        row_t;
  typedef logic signed [15:0] rot_t;
  typedef logic [1:0]         cfg_idx_t;

  // Configuration register indexes.
  localparam cfg_idx_t CFG_ROT_ROW0 = 2'd0;
  localparam cfg_idx_t CFG_ROT_ROW1 = 2'd1;
  localparam cfg_idx_t CFG_ROT_ROW2 = 2'd2;

  // Identity matrix in Q2.14.
  localparam row_t ROT_ROW0_RST = 48'h0000_0000_4000;
  localparam row_t ROT_ROW1_RST = 48'h0000_4000_0000;
  localparam row_t ROT_ROW2_RST = 48'h4000_0000_0000;

  localparam int RotShift  = 14;
  localparam int PipeDepth = 7;

  localparam logic signed [63:0] CoordMax = 64'sd2147483647;
  localparam logic signed [63:0] CoordMin = -64'sd2147483648;

  function automatic coord_t sat_coord(input logic signed [63:0] v);
    coord_t res;
    if (v > CoordMax) begin
      res = 32'sh7fff_ffff;
    end else if (v < CoordMin) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

endpackage

// ----- hdl/asrt_if.sv -----
// ----------------------------------------------------------------------------
// asrt_if: valid/ready channels of the box scale/rotate/translate unit
// One interface for input transactions and one for result transactions.
// ----------------------------------------------------------------------------
interface asrt_in_if;
  import asrt_pkg::*;

  logic   valid;
  logic   ready;
  coord_t in_min_x;
  coord_t in_min_y;
  coord_t in_min_z;
  coord_t in_max_x;
  coord_t in_max_y;
  coord_t in_max_z;
  coord_t move_x;
  coord_t move_y;
  coord_t move_z;
  coord_t gain_x;
  coord_t gain_y;
  coord_t gain_z;

  modport source (
    output valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
           move_x, move_y, move_z, gain_x, gain_y, gain_z,
    input  ready
  );

  modport sink (
    input  valid, in_min_x, in_min_y, in_min_z, in_max_x, in_max_y, in_max_z,
           move_x, move_y, move_z, gain_x, gain_y, gain_z,
    output ready
  );
endinterface

interface asrt_out_if;
  import asrt_pkg::*;

  logic   valid;
  logic   ready;
  coord_t out_min_x;
  coord_t out_min_y;
  coord_t out_min_z;
  coord_t out_max_x;
  coord_t out_max_y;
  coord_t out_max_z;

  modport source (
    output valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
    input  ready
  );

  modport sink (
    input  valid, out_min_x, out_min_y, out_min_z, out_max_x, out_max_y, out_max_z,
    output ready
  );
endinterface

// ----- hdl/aabb_scale_rotate_translate_unit.sv -----
// ----------------------------------------------------------------------------
// aabb_scale_rotate_translate_unit: bounds a scaled, rotated, moved box
// Seven-stage pipeline: center/extent, scale multiply, saturate, matrix
// multiply, per-term min/max, sums, final rounding and saturation.
// ----------------------------------------------------------------------------
// Usage:
// The in_ch channel takes one box per transaction: min and max corners, a
// translation and a per-axis scale, all signed Q16.16. The out_ch channel
// returns the bounding box of the scaled, rotated and translated box, one
// result transaction per input transaction, in order.
// The 3x3 rotation (Q2.14) lives in three registers written through cfg_we,
// cfg_idx and cfg_wdata; write them only while no transaction is in flight.
// The pipeline takes one transaction per cycle while the receiver does not
// stall; the depth is set by the scale multiplier (33x32 bits) and the
// matrix multipliers (16x32 bits), each followed by its own register stage.
// Synchronous reset (rst_n low) empties the pipeline and loads the identity
// matrix. When the receiver stalls, the output register holds its result and
// the stages behind it keep filling empty slots; in_ch.ready drops only once
// every stage holds a transaction.
// ----------------------------------------------------------------------------
module aabb_scale_rotate_translate_unit (
  input  logic               clk,
  input  logic               rst_n,
  asrt_in_if.sink            in_ch,
  asrt_out_if.source         out_ch,
  input  logic               cfg_we,
  input  asrt_pkg::cfg_idx_t cfg_idx,
  input  asrt_pkg::row_t     cfg_wdata
);
  import asrt_pkg::*;

  row_t        rot_row_r [3];
  logic [6:0]  vld_r;
  logic [6:0]  en;

  coord_t      in_lo [3];
  coord_t      in_hi [3];
  coord_t      in_gain [3];
  coord_t      in_move [3];

  // Stage 1: center and full extent.
  logic signed [32:0] s1_dif_nxt [3];
  coord_t             s1_ctr_nxt [3];
  logic signed [32:0] s1_dif_r [3];
  coord_t             s1_ctr_r [3];
  coord_t             s1_gain_r [3];
  coord_t             s1_mov_r [3];
  // Stage 2: extent times scale.
  logic signed [64:0] s2_prd_r [3];
  coord_t             s2_ctr_r [3];
  coord_t             s2_mov_r [3];
  // Stage 3: scaled corners.
  coord_t             s3_min_nxt [3];
  coord_t             s3_max_nxt [3];
  coord_t             s3_min_r [3];
  coord_t             s3_max_r [3];
  coord_t             s3_mov_r [3];
  // Stage 4: matrix products, indexed [row j][column i].
  logic signed [47:0] s4_pa_r [3][3];
  logic signed [47:0] s4_pb_r [3][3];
  coord_t             s4_mov_r [3];
  // Stage 5: ordered terms, indexed [output axis i][row j].
  logic signed [47:0] s5_lo_r [3][3];
  logic signed [47:0] s5_hi_r [3][3];
  coord_t             s5_mov_r [3];
  // Stage 6: sums, the high one already biased for rounding up.
  logic signed [50:0] s6_lo_nxt [3];
  logic signed [50:0] s6_hi_nxt [3];
  logic signed [50:0] s6_lo_r [3];
  logic signed [50:0] s6_hi_r [3];
  // Stage 7: output register.
  coord_t             s7_min_r [3];
  coord_t             s7_max_r [3];

  assign in_lo[0]   = in_ch.in_min_x;
  assign in_lo[1]   = in_ch.in_min_y;
  assign in_lo[2]   = in_ch.in_min_z;
  assign in_hi[0]   = in_ch.in_max_x;
  assign in_hi[1]   = in_ch.in_max_y;
  assign in_hi[2]   = in_ch.in_max_z;
  assign in_gain[0] = in_ch.gain_x;
  assign in_gain[1] = in_ch.gain_y;
  assign in_gain[2] = in_ch.gain_z;
  assign in_move[0] = in_ch.move_x;
  assign in_move[1] = in_ch.move_y;
  assign in_move[2] = in_ch.move_z;

  // A stage advances when it is empty or the stage after it advances.
  always_comb begin
    en[6] = !vld_r[6] || out_ch.ready;
    for (int k = 5; k >= 0; k--) begin
      en[k] = !vld_r[k] || en[k+1];
    end
  end

  assign in_ch.ready = en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rot_row_r[0] <= ROT_ROW0_RST;
      rot_row_r[1] <= ROT_ROW1_RST;
      rot_row_r[2] <= ROT_ROW2_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_ROT_ROW0: rot_row_r[0] <= cfg_wdata;
        CFG_ROT_ROW1: rot_row_r[1] <= cfg_wdata;
        CFG_ROT_ROW2: rot_row_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= in_ch.valid;
      for (int k = 1; k < 7; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 1 and stage 3 next values.
  always_comb begin
    logic signed [32:0] sum;
    logic signed [47:0] ext;
    for (int j = 0; j < 3; j++) begin
      sum = 33'(in_lo[j]) + 33'(in_hi[j]);
      s1_ctr_nxt[j] = sum[32:1];
      s1_dif_nxt[j] = 33'(in_hi[j]) - 33'(in_lo[j]);
      ext = s2_prd_r[j][64:17];
      s3_min_nxt[j] = sat_coord(64'(49'(s2_ctr_r[j]) - 49'(ext)));
      s3_max_nxt[j] = sat_coord(64'(49'(s2_ctr_r[j]) + 49'(ext)));
    end
  end

  // Stage 6 next values: translation scaled to Q16.30 plus the three terms.
  always_comb begin
    logic signed [45:0] mv;
    for (int i = 0; i < 3; i++) begin
      mv = {s5_mov_r[i], 14'd0};
      s6_lo_nxt[i] = 51'(mv) + 51'(s5_lo_r[i][0]) + 51'(s5_lo_r[i][1])
                   + 51'(s5_lo_r[i][2]);
      s6_hi_nxt[i] = 51'(mv) + 51'(s5_hi_r[i][0]) + 51'(s5_hi_r[i][1])
                   + 51'(s5_hi_r[i][2]) + 51'((1 << RotShift) - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_dif_r  <= s1_dif_nxt;
      s1_ctr_r  <= s1_ctr_nxt;
      s1_gain_r <= in_gain;
      s1_mov_r  <= in_move;
    end
    if (en[1]) begin
      for (int j = 0; j < 3; j++) begin
        s2_prd_r[j] <= 65'(s1_dif_r[j]) * 65'(s1_gain_r[j]);
      end
      s2_ctr_r <= s1_ctr_r;
      s2_mov_r <= s1_mov_r;
    end
    if (en[2]) begin
      s3_min_r <= s3_min_nxt;
      s3_max_r <= s3_max_nxt;
      s3_mov_r <= s2_mov_r;
    end
    if (en[3]) begin
      for (int j = 0; j < 3; j++) begin
        for (int i = 0; i < 3; i++) begin
          s4_pa_r[j][i] <= 48'(rot_t'(rot_row_r[j][16*i +: 16])) * 48'(s3_min_r[j]);
          s4_pb_r[j][i] <= 48'(rot_t'(rot_row_r[j][16*i +: 16])) * 48'(s3_max_r[j]);
        end
      end
      s4_mov_r <= s3_mov_r;
    end
    if (en[4]) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          if (s4_pa_r[j][i] < s4_pb_r[j][i]) begin
            s5_lo_r[i][j] <= s4_pa_r[j][i];
            s5_hi_r[i][j] <= s4_pb_r[j][i];
          end else begin
            s5_lo_r[i][j] <= s4_pb_r[j][i];
            s5_hi_r[i][j] <= s4_pa_r[j][i];
          end
        end
      end
      s5_mov_r <= s4_mov_r;
    end
    if (en[5]) begin
      s6_lo_r <= s6_lo_nxt;
      s6_hi_r <= s6_hi_nxt;
    end
    if (en[6]) begin
      // The arithmetic shift floors; the bias added before makes it a ceiling.
      for (int i = 0; i < 3; i++) begin
        s7_min_r[i] <= sat_coord(64'(s6_lo_r[i] >>> RotShift));
        s7_max_r[i] <= sat_coord(64'(s6_hi_r[i] >>> RotShift));
      end
    end
  end

  assign out_ch.valid     = vld_r[6];
  assign out_ch.out_min_x = s7_min_r[0];
  assign out_ch.out_min_y = s7_min_r[1];
  assign out_ch.out_min_z = s7_min_r[2];
  assign out_ch.out_max_x = s7_max_r[0];
  assign out_ch.out_max_y = s7_max_r[1];
  assign out_ch.out_max_z = s7_max_r[2];

endmodule

// ----- hdl/asrt_chk.sv -----
// ----------------------------------------------------------------------------
// asrt_chk: port-level checks for the box scale/rotate/translate unit
// Tracks transactions in flight and checks stall and occupancy behavior.
// ----------------------------------------------------------------------------
module asrt_chk (
  input logic         clk,
  input logic         rst_n,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input logic [191:0] out_data
);
  import asrt_pkg::*;

  logic [3:0] cnt_r;
  logic [3:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r + 4'(in_valid && in_ready) - 4'(out_valid && out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // With the output register empty, every stage can move, so input is taken.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while output register is empty");

  // No more transactions in flight than pipeline stages.
  a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 4'(PipeDepth))
    else $error("more transactions in flight than stages");

  // A result is never shown without a transaction behind it.
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != 4'd0)
    else $error("result without an accepted transaction");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind aabb_scale_rotate_translate_unit asrt_chk u_asrt_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  ({out_ch.out_min_x, out_ch.out_min_y, out_ch.out_min_z,
               out_ch.out_max_x, out_ch.out_max_y, out_ch.out_max_z})
);

// ----- bench/aabb_scale_rotate_translate_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_scale_rotate_translate_unit_tb: self-checking bench for the box unit
// Drives boxes through the valid/ready input channel under bursty traffic
// and receiver stalls, predicts every bound from a bit-accurate fixed-point
// model of scale, Arvo bounding and translation, and compares each result.
// ----------------------------------------------------------------------------
module aabb_scale_rotate_translate_unit_tb;
  import asrt_pkg::*;

  localparam cfg_idx_t CFG_IDX_SPARE = 2'd3;
  localparam int       CycleLimit    = 200000;

  typedef logic signed [79:0] wide_t;

  typedef struct packed {
    coord_t [2:0] lo;
    coord_t [2:0] hi;
    coord_t [2:0] mv;
    coord_t [2:0] gain;
  } box_req_t;

  typedef struct packed {
    coord_t [2:0] lo;
    coord_t [2:0] hi;
  } box_bound_t;

  logic     clk = 1'b0;
  logic     rst_n;
  logic     cfg_we;
  cfg_idx_t cfg_idx;
  row_t     cfg_wdata;

  asrt_in_if  in_ch ();
  asrt_out_if out_ch ();

  aabb_scale_rotate_translate_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  row_t       rot_q [3] = '{ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST};
  box_bound_t bound_q [$];
  box_bound_t got_bound;
  box_bound_t want_bound;
  int         errors = 0;
  int         cycle_count = 0;
  int         burst_left = 1;
  int         holdoff_req = 0;
  bit         gaps_on = 1'b0;
  bit         stalls_on = 1'b0;
  string      axis_names = "xyz";

  function automatic wide_t widen(input coord_t v);
    return wide_t'(v);
  endfunction

  function automatic wide_t clip_q16(input wide_t v);
    if (v > CoordMax) begin
      return wide_t'(CoordMax);
    end else if (v < CoordMin) begin
      return wide_t'(CoordMin);
    end
    return v;
  endfunction

  // Scale about the center, bound under the matrix per Arvo, then translate.
  function automatic box_bound_t bound_moved_box(input box_req_t b);
    wide_t      smin [3];
    wide_t      smax [3];
    wide_t      lo_w, hi_w, ctr, half_ext, low, high, coef, pa, pb;
    rot_t       entry;
    box_bound_t r;
    for (int j = 0; j < 3; j++) begin
      lo_w     = widen(b.lo[j]);
      hi_w     = widen(b.hi[j]);
      ctr      = (lo_w + hi_w) >>> 1;
      half_ext = ((hi_w - lo_w) * widen(b.gain[j])) >>> 17;
      smin[j]  = clip_q16(ctr - half_ext);
      smax[j]  = clip_q16(ctr + half_ext);
    end
    for (int i = 0; i < 3; i++) begin
      low  = widen(b.mv[i]) <<< RotShift;
      high = low;
      for (int j = 0; j < 3; j++) begin
        entry = rot_q[j][16*i +: 16];
        coef  = wide_t'(entry);
        pa    = coef * smin[j];
        pb    = coef * smax[j];
        if (pa < pb) begin
          low  += pa;
          high += pb;
        end else begin
          low  += pb;
          high += pa;
        end
      end
      // Floor the minimum and ceil the maximum so the bound stays conservative.
      low     = clip_q16(low >>> RotShift);
      high    = clip_q16(-((-high) >>> RotShift));
      r.lo[i] = low[31:0];
      r.hi[i] = high[31:0];
    end
    return r;
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          2:       return 32'h0000_0000;
          default: return 32'hffff_ffff;
        endcase
      end
      1, 2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
    endcase
  endfunction

  function automatic coord_t pick_gain();
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 2))
          0:       return 32'h8000_0000;
          1:       return 32'h7fff_ffff;
          default: return 32'h0000_0000;
        endcase
      end
      1:       return $urandom;
      2:       return 32'hffff_0000 - $urandom_range(0, 32'h0002_0000);
      default: return 32'h0001_0000 + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endcase
  endfunction

  // Mostly ordered boxes; the rest take independent corners and may be inverted.
  function automatic box_req_t rand_box();
    box_req_t b;
    for (int a = 0; a < 3; a++) begin
      b.lo[a] = pick_coord();
      if ($urandom_range(0, 7) != 0) begin
        b.hi[a] = b.lo[a] + $urandom_range(0, 32'h0100_0000);
      end else begin
        b.hi[a] = pick_coord();
      end
      b.mv[a]   = pick_coord();
      b.gain[a] = pick_gain();
    end
    return b;
  endfunction

  function automatic box_req_t uniform_box(input coord_t lo, input coord_t hi,
                                           input coord_t mv, input coord_t gain);
    box_req_t b;
    for (int a = 0; a < 3; a++) begin
      b.lo[a]   = lo;
      b.hi[a]   = hi;
      b.mv[a]   = mv;
      b.gain[a] = gain;
    end
    return b;
  endfunction

  function automatic rot_t pick_entry();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'h0000;
      3:       return 16'h4000;
      4:       return 16'hc000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic row_t rand_row();
    return {pick_entry(), pick_entry(), pick_entry()};
  endfunction

  task automatic send_box(input box_req_t b);
    int gap;
    in_ch.valid    <= 1'b1;
    in_ch.in_min_x <= b.lo[0];
    in_ch.in_min_y <= b.lo[1];
    in_ch.in_min_z <= b.lo[2];
    in_ch.in_max_x <= b.hi[0];
    in_ch.in_max_y <= b.hi[1];
    in_ch.in_max_z <= b.hi[2];
    in_ch.move_x   <= b.mv[0];
    in_ch.move_y   <= b.mv[1];
    in_ch.move_z   <= b.mv[2];
    in_ch.gain_x   <= b.gain[0];
    in_ch.gain_y   <= b.gain[1];
    in_ch.gain_z   <= b.gain[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    bound_q.push_back(bound_moved_box(b));
    if (gaps_on) begin
      burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(1, 12);
        gap        = $urandom_range(1, 8);
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (bound_q.size() != 0) @(posedge clk);
  endtask

  // Rows are written back to back, then optionally the unused index.
  task automatic load_matrix(input row_t r0, input row_t r1, input row_t r2,
                             input bit poke_spare);
    drain();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_ROT_ROW0;
    cfg_wdata <= r0;
    @(posedge clk);
    rot_q[0] = r0;
    cfg_idx   <= CFG_ROT_ROW1;
    cfg_wdata <= r1;
    @(posedge clk);
    rot_q[1] = r1;
    cfg_idx   <= CFG_ROT_ROW2;
    cfg_wdata <= r2;
    @(posedge clk);
    rot_q[2] = r2;
    if (poke_spare) begin
      cfg_idx   <= CFG_IDX_SPARE;
      cfg_wdata <= rand_row();
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic test_identity_cases();
    send_box(uniform_box(32'hffff_0000, 32'h0001_0000, 32'h0000_8000, 32'h0001_0000));
    send_box(uniform_box(32'h0003_0000, 32'h0007_0000, 32'hffff_ffff, 32'h0000_0000));
    send_box(uniform_box(32'h0001_0000, 32'h0005_0000, 32'h0000_0000, 32'hfffe_0000));
    send_box(uniform_box(32'h0004_0000, 32'hfffc_0000, 32'h0000_0000, 32'h0001_0000));
    send_box(uniform_box(32'hffff_ffff, 32'h0000_0002, 32'h0000_0001, 32'h0000_0003));
  endtask

  task automatic test_field_extremes();
    send_box(uniform_box(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_box(uniform_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    send_box(uniform_box(32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h8000_0000));
    send_box(uniform_box(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000));
    send_box(uniform_box(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
  endtask

  task automatic test_matrix_extremes();
    load_matrix(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000, 1'b1);
    send_box(uniform_box(32'hffff_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
    send_box(uniform_box(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_box(uniform_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    send_box(uniform_box(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
    load_matrix(48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 48'h7fff_7fff_7fff, 1'b0);
    send_box(uniform_box(32'hffff_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
    send_box(uniform_box(32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    send_box(uniform_box(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000));
    send_box(uniform_box(32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 32'h0001_0000));
    // Quarter turn about z: zero entries give equal products on both corners.
    load_matrix(48'h0000_4000_0000, 48'h0000_0000_c000, 48'h4000_0000_0000, 1'b0);
    send_box(uniform_box(32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000));
    send_box(uniform_box(32'hfffe_0000, 32'h0002_0000, 32'h0000_0000, 32'hffff_0000));
    send_box(rand_box());
  endtask

  task automatic test_backpressure();
    drain();
    gaps_on     = 1'b0;
    stalls_on   = 1'b0;
    holdoff_req = 48;
    repeat (32) send_box(rand_box());
    drain();
    gaps_on     = 1'b1;
    stalls_on   = 1'b1;
    holdoff_req = 30;
    repeat (40) send_box(rand_box());
    drain();
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       load_matrix(ROT_ROW1_RST, ROT_ROW2_RST, ROT_ROW0_RST, 1'b1);
        1:       load_matrix(48'hffff_ffff_ffff, 48'h0, 48'h8000_7fff_8000, 1'b1);
        default: load_matrix(rand_row(), rand_row(), rand_row(), 1'b1);
      endcase
      gaps_on   = (p != 2);
      stalls_on = (p != 2);
      repeat (130) send_box(rand_box());
    end
    load_matrix(ROT_ROW0_RST, ROT_ROW1_RST, ROT_ROW2_RST, 1'b0);
    repeat (40) send_box(rand_box());
  endtask

  // Receiver: a rotating random ready pattern, plus long hold-offs on request.
  initial begin : rx_stall
    logic [15:0] stall_pat;
    int          pat_age;
    int          hold_left;
    stall_pat = 16'hffff;
    pat_age   = 0;
    hold_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holdoff_req != 0) begin
        hold_left   = holdoff_req;
        holdoff_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!stalls_on) begin
        out_ch.ready <= 1'b1;
      end else begin
        pat_age++;
        if (pat_age == 16) begin
          pat_age   = 0;
          stall_pat = 16'($urandom);
        end
        stall_pat = {stall_pat[14:0], stall_pat[15]};
        out_ch.ready <= stall_pat[0];
      end
    end
  end

  // Every accepted result transaction is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got_bound.lo[0] = out_ch.out_min_x;
      got_bound.lo[1] = out_ch.out_min_y;
      got_bound.lo[2] = out_ch.out_min_z;
      got_bound.hi[0] = out_ch.out_max_x;
      got_bound.hi[1] = out_ch.out_max_y;
      got_bound.hi[2] = out_ch.out_max_z;
      if (bound_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result transaction, min=%h max=%h", $time,
                 got_bound.lo, got_bound.hi);
      end else begin
        want_bound = bound_q.pop_front();
        for (int f = 0; f < 6; f++) begin
          if (((f < 3) ? got_bound.lo[f % 3] : got_bound.hi[f % 3]) !==
              ((f < 3) ? want_bound.lo[f % 3] : want_bound.hi[f % 3])) begin
            errors++;
            $display("%0t: out_%s_%c mismatch, expected 0x%08h, actual 0x%08h", $time,
                     (f < 3) ? "min" : "max", axis_names[f % 3],
                     (f < 3) ? want_bound.lo[f % 3] : want_bound.hi[f % 3],
                     (f < 3) ? got_bound.lo[f % 3] : got_bound.hi[f % 3]);
          end
        end
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_ROT_ROW0;
    cfg_wdata      <= '0;
    in_ch.valid    <= 1'b0;
    in_ch.in_min_x <= '0;
    in_ch.in_min_y <= '0;
    in_ch.in_min_z <= '0;
    in_ch.in_max_x <= '0;
    in_ch.in_max_y <= '0;
    in_ch.in_max_z <= '0;
    in_ch.move_x   <= '0;
    in_ch.move_y   <= '0;
    in_ch.move_z   <= '0;
    in_ch.gain_x   <= '0;
    in_ch.gain_y   <= '0;
    in_ch.gain_z   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_identity_cases();
    test_field_extremes();
    test_matrix_extremes();
    test_backpressure();
    test_random_phases();
    drain();
    repeat (PipeDepth + 4) @(posedge clk);
    if (errors == 0 && bound_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
